>>> design/srlfo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srlfo_pkg
// shared types, constants and elaboration-time table functions for the
// stereo random-amplitude lfo
// ----------------------------------------------------------------------------
package srlfo_pkg;

    localparam int PHASE_BITS_DEF      = 24;
    localparam int SINE_TABLE_BITS_DEF = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANDOMNESS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_TYPE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_OFFSET = 2'd3;

    localparam logic [22:0] PHASE_STEP_RST    = 23'd23006;
    localparam logic [6:0]  RANDOMNESS_RST    = 7'd0;
    localparam logic        WAVE_TYPE_RST     = 1'b0;
    localparam logic [6:0]  STEREO_OFFSET_RST = 7'd96;

    localparam logic [15:0] AMP_ONE = 16'd32768;

    // shared multiplier operand a is always narrow
    localparam int MUL_A_W = 18;

    // reciprocal of 127 in q0.21, slightly low so the estimate is never high
    localparam logic [MUL_A_W-1:0] RECIP_127 = 18'd16513;
    localparam logic [22:0]        DIV_ROUND = 23'd127;
    localparam logic [33:0]        LEVEL_BIAS = 34'h0_4000_4000;

    localparam logic              WAVE_SINE = 1'b0;
    localparam logic              KIND_TICK = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AMP,
        ST_LVL,
        ST_SAT,
        ST_DIV,
        ST_COR,
        ST_OUT
    } t_state;

    // quarter-wave cosine entry in q1.15 from a fixed degree-12 series
    function automatic logic [15:0] quarter_cos(int unsigned idx, int unsigned bits);
        logic [63:0] coef [7];
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] acc;
        logic [63:0] p;
        logic [63:0] rnd;
        coef[0] = 64'd1073741824;
        coef[1] = 64'd1324675879;
        coef[2] = 64'd272375560;
        coef[3] = 64'd22401992;
        coef[4] = 64'd987048;
        coef[5] = 64'd27060;
        coef[6] = 64'd506;
        t   = (64'(idx) << 30) >> bits;
        u   = (t * t) >> 30;
        acc = coef[6];
        for (int k = 5; k >= 0; k--) begin
            p   = (u * acc) >> 30;
            acc = (p > coef[k]) ? 64'd0 : coef[k] - p;
        end
        rnd = (acc + 64'd16384) >> 15;
        return rnd[15:0];
    endfunction

    // rounded right-channel phase offset, not yet wrapped to the phase width
    function automatic logic [63:0] phase_offset(int unsigned so, int unsigned pbits);
        logic [63:0] num;
        num = ((64'(so) + 64'd63) << pbits) + 64'd63;
        return num / 64'd127;
    endfunction

endpackage
`default_nettype wire

>>> design/srlfo_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srlfo_mul
// shared signed multiplier with a registered product
// ----------------------------------------------------------------------------
module srlfo_mul #(
    parameter int MUL_B_W = 25
) (
    input  wire logic                                          i_clk,
    input  wire logic signed [srlfo_pkg::MUL_A_W-1:0]          i_a,
    input  wire logic signed [MUL_B_W-1:0]                     i_b,
    output logic signed [srlfo_pkg::MUL_A_W+MUL_B_W-1:0]       o_p
);

    logic signed [srlfo_pkg::MUL_A_W+MUL_B_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

>>> design/srlfo_wave.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srlfo_wave
// waveform shape at a phase: quarter-wave cosine table or triangle, q1.15
// ----------------------------------------------------------------------------
module srlfo_wave #(
    parameter int PHASE_BITS      = srlfo_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = srlfo_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic [PHASE_BITS-1:0] i_phase,
    input  wire logic                  i_wave_type,
    output logic signed [17:0]         o_shape
);

    localparam int TAB_N = 2 ** SINE_TABLE_BITS;
    localparam logic [SINE_TABLE_BITS-1:0] IDX_ONE = SINE_TABLE_BITS'(1);

    logic [15:0] w_tab [TAB_N];

    for (genvar gi = 0; gi < TAB_N; gi++) begin : g_tab
        localparam logic [15:0] ENTRY = srlfo_pkg::quarter_cos(gi, SINE_TABLE_BITS);
        assign w_tab[gi] = ENTRY;
    end

    logic [1:0]                  w_quad;
    logic [SINE_TABLE_BITS-1:0]  w_i;
    logic [SINE_TABLE_BITS-1:0]  w_mi;
    logic signed [17:0]          w_direct;
    logic signed [17:0]          w_mirror;
    logic [PHASE_BITS+16:0]      w_fx;
    logic signed [17:0]          w_f;
    logic signed [17:0]          w_sine;
    logic signed [17:0]          w_tri;

    assign w_quad   = i_phase[PHASE_BITS-1 -: 2];
    assign w_i      = i_phase[PHASE_BITS-3 -: SINE_TABLE_BITS];
    assign w_mi     = ~w_i + IDX_ONE;
    assign w_direct = {2'b00, w_tab[w_i]};
    // cosine of a quarter is taken as zero
    assign w_mirror = (w_i == '0) ? 18'sd0 : {2'b00, w_tab[w_mi]};

    assign w_fx = {i_phase, 17'b0} >> PHASE_BITS;
    assign w_f  = {1'b0, w_fx[16:0]};

    always_comb begin
        case (w_quad)
            2'b00:   w_sine = w_direct;
            2'b01:   w_sine = -w_mirror;
            2'b10:   w_sine = -w_direct;
            default: w_sine = w_mirror;
        endcase
    end

    // half-open intervals: exact quarter points open the next segment
    always_comb begin
        case (w_quad)
            2'b00:   w_tri = w_f;
            2'b01:   w_tri = 18'sd65536 - w_f;
            2'b10:   w_tri = 18'sd65536 - w_f;
            default: w_tri = w_f - 18'sd131072;
        endcase
    end

    assign o_shape = (i_wave_type == srlfo_pkg::WAVE_SINE) ? w_sine : w_tri;

endmodule
`default_nettype wire

>>> design/stereo_random_amplitude_lfo_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_random_amplitude_lfo_core
// stereo lfo with per-cycle random amplitude, one shared multiplier
// under a small sequencer
// ----------------------------------------------------------------------------
//  channel   signals                                     direction
//  in        i_in_valid/o_in_ready, i_kind, i_random_*   request in
//  out       o_out_valid/i_out_ready, o_*_level          request out
//  cfg       i_cfg_we, i_cfg_index, i_cfg_data           register write
//
//  a tick steps the amplitude, level and saturate states per channel, plus
//  divide and correct for a wrapping channel; each channel runs amplitude,
//  level and optional end-level draw through the one shared multiplier
//  a realign is done at accept, ready stays high; right phase from a table
//  ready is low while a tick is in work; the result waits in an output
//  register, and the next request is taken while it is still pending;
//  that tick then holds before its load until the register is free
//  reset is synchronous and needs no clearing pass
// ----------------------------------------------------------------------------
module stereo_random_amplitude_lfo_core #(
    parameter int PHASE_BITS      = srlfo_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = srlfo_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_kind,
    input  wire logic [15:0]                         i_random_left,
    input  wire logic [15:0]                         i_random_right,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [15:0]                              o_left_level,
    output logic [15:0]                              o_right_level,
    input  wire logic                                i_cfg_we,
    input  wire logic [srlfo_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [srlfo_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int MUL_B_W = (PHASE_BITS + 1 > 23) ? PHASE_BITS + 1 : 23;
    localparam int MUL_P_W = srlfo_pkg::MUL_A_W + MUL_B_W;
    localparam int STEP_SH = 32 - PHASE_BITS;
    localparam int OFF_N   = 128;

    localparam logic [63:0] OFF_RST_FULL =
        srlfo_pkg::phase_offset(32'(srlfo_pkg::STEREO_OFFSET_RST), PHASE_BITS);
    localparam logic [PHASE_BITS-1:0] OFF_RST = OFF_RST_FULL[PHASE_BITS-1:0];

    // right-phase offset for every stereo_offset code
    logic [PHASE_BITS-1:0] w_off_tab [OFF_N];
    for (genvar gi = 0; gi < OFF_N; gi++) begin : g_off
        localparam logic [63:0] OFF = srlfo_pkg::phase_offset(gi, PHASE_BITS);
        assign w_off_tab[gi] = OFF[PHASE_BITS-1:0];
    end

    // configuration
    logic [22:0] r_phase_step;
    logic [6:0]  r_randomness;
    logic        r_wave_type;
    logic [6:0]  r_stereo_offset;

    // oscillator state
    logic [PHASE_BITS-1:0] r_phase_l;
    logic [PHASE_BITS-1:0] r_phase_r;
    logic [15:0]           r_amp0_l;
    logic [15:0]           r_amp1_l;
    logic [15:0]           r_amp0_r;
    logic [15:0]           r_amp1_r;

    // sequencer and working registers
    srlfo_pkg::t_state r_state;
    srlfo_pkg::t_state n_state;
    logic               r_ch;
    logic [15:0]        r_rnd_l;
    logic [15:0]        r_rnd_r;
    logic signed [17:0] r_shape;
    logic [21:0]        r_m;
    logic [15:0]        r_lvl_l;
    logic [15:0]        r_lvl_r;
    logic               r_out_valid;
    logic [15:0]        r_out_l;
    logic [15:0]        r_out_r;

    logic                                  w_in_acc;
    logic                                  w_out_load;
    logic [PHASE_BITS-1:0]                 w_x;
    logic [15:0]                           w_a0;
    logic [15:0]                           w_a1;
    logic [15:0]                           w_rnd;
    logic signed [16:0]                    w_diff;
    logic signed [17:0]                    w_shape;
    logic signed [srlfo_pkg::MUL_A_W-1:0]  w_mul_a;
    logic signed [MUL_B_W-1:0]             w_mul_b;
    logic signed [MUL_P_W-1:0]             w_prod;
    logic signed [MUL_P_W-1:0]             w_amp_sh;
    logic [17:0]                           w_amp_sum;
    logic [15:0]                           w_amp;
    logic [33:0]                           w_s;
    logic [15:0]                           w_level;
    logic [31:0]                           w_step32;
    logic [PHASE_BITS:0]                   w_nx;
    logic [16:0]                           w_rnd_inv;
    logic [22:0]                           w_n;
    logic [15:0]                           w_q_est;
    logic [22:0]                           w_qx127;
    logic [22:0]                           w_rem;
    logic [15:0]                           w_drop;
    logic [15:0]                           w_new_end;

    srlfo_wave #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_wave (
        .i_phase     (w_x),
        .i_wave_type (r_wave_type),
        .o_shape     (w_shape)
    );

    srlfo_mul #(
        .MUL_B_W (MUL_B_W)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_load = (r_state == srlfo_pkg::ST_OUT) && (!r_out_valid || i_out_ready);

    assign w_x   = r_ch ? r_phase_r : r_phase_l;
    assign w_a0  = r_ch ? r_amp0_r  : r_amp0_l;
    assign w_a1  = r_ch ? r_amp1_r  : r_amp1_l;
    assign w_rnd = r_ch ? r_rnd_r   : r_rnd_l;

    assign w_diff = $signed({1'b0, w_a1}) - $signed({1'b0, w_a0});

    // amp = a0 + floor((a1 - a0) * x / one)
    assign w_amp_sh  = w_prod >>> PHASE_BITS;
    assign w_amp_sum = {2'b00, w_a0} + w_amp_sh[17:0];
    assign w_amp     = w_amp_sum[15:0];

    // level = (shape * amp + 2^30 + 2^14) >> 15, saturated
    assign w_s = w_prod[33:0] + srlfo_pkg::LEVEL_BIAS;
    always_comb begin
        if (w_s[33]) begin
            w_level = 16'd0;
        end else if (w_s[32:31] != 2'b00) begin
            w_level = 16'hFFFF;
        end else begin
            w_level = w_s[30:15];
        end
    end

    assign w_step32 = {1'b0, r_phase_step, 8'b0} >> STEP_SH;
    assign w_nx     = {1'b0, w_x} + {1'b0, w_step32[PHASE_BITS-1:0]};

    assign w_rnd_inv = 17'h10000 - {1'b0, w_rnd};

    // drop = (randomness * (65536 - r) + 127) / 254, halved then over 127
    assign w_n       = w_prod[22:0] + srlfo_pkg::DIV_ROUND;
    assign w_q_est   = w_prod[36:21];
    assign w_qx127   = {w_q_est, 7'b0} - {7'b0, w_q_est};
    assign w_rem     = {1'b0, r_m} - w_qx127;
    assign w_drop    = (w_rem >= srlfo_pkg::DIV_ROUND) ? w_q_est + 16'd1 : w_q_est;
    assign w_new_end = (w_drop > srlfo_pkg::AMP_ONE) ? 16'd0 : srlfo_pkg::AMP_ONE - w_drop;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            srlfo_pkg::ST_IDLE: begin
                if (w_in_acc && i_kind == srlfo_pkg::KIND_TICK) begin
                    n_state = srlfo_pkg::ST_AMP;
                end
            end
            srlfo_pkg::ST_AMP: n_state = srlfo_pkg::ST_LVL;
            srlfo_pkg::ST_LVL: n_state = srlfo_pkg::ST_SAT;
            srlfo_pkg::ST_SAT: begin
                if (w_nx[PHASE_BITS]) begin
                    n_state = srlfo_pkg::ST_DIV;
                end else if (r_ch) begin
                    n_state = srlfo_pkg::ST_OUT;
                end else begin
                    n_state = srlfo_pkg::ST_AMP;
                end
            end
            srlfo_pkg::ST_DIV: n_state = srlfo_pkg::ST_COR;
            srlfo_pkg::ST_COR: n_state = r_ch ? srlfo_pkg::ST_OUT : srlfo_pkg::ST_AMP;
            srlfo_pkg::ST_OUT: begin
                if (w_out_load) begin
                    n_state = srlfo_pkg::ST_IDLE;
                end
            end
            default: n_state = srlfo_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer: ready and multiplier operands
    always_comb begin
        o_in_ready = 1'b0;
        w_mul_a    = '0;
        w_mul_b    = '0;
        case (r_state)
            srlfo_pkg::ST_IDLE: o_in_ready = 1'b1;
            srlfo_pkg::ST_AMP: begin
                w_mul_a                  = {w_diff[16], w_diff};
                w_mul_b[PHASE_BITS-1:0]  = w_x;
            end
            srlfo_pkg::ST_LVL: begin
                w_mul_a       = r_shape;
                w_mul_b[15:0] = w_amp;
            end
            srlfo_pkg::ST_SAT: begin
                w_mul_a       = {11'b0, r_randomness};
                w_mul_b[16:0] = w_rnd_inv;
            end
            srlfo_pkg::ST_DIV: begin
                w_mul_a       = srlfo_pkg::RECIP_127;
                w_mul_b[21:0] = w_n[22:1];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= srlfo_pkg::ST_IDLE;
            r_ch            <= 1'b0;
            r_out_valid     <= 1'b0;
            r_phase_step    <= srlfo_pkg::PHASE_STEP_RST;
            r_randomness    <= srlfo_pkg::RANDOMNESS_RST;
            r_wave_type     <= srlfo_pkg::WAVE_TYPE_RST;
            r_stereo_offset <= srlfo_pkg::STEREO_OFFSET_RST;
            r_phase_l       <= '0;
            r_phase_r       <= OFF_RST;
            r_amp0_l        <= srlfo_pkg::AMP_ONE;
            r_amp1_l        <= srlfo_pkg::AMP_ONE;
            r_amp0_r        <= srlfo_pkg::AMP_ONE;
            r_amp1_r        <= srlfo_pkg::AMP_ONE;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    srlfo_pkg::CFG_PHASE_STEP:    r_phase_step    <= i_cfg_data[22:0];
                    srlfo_pkg::CFG_RANDOMNESS:    r_randomness    <= i_cfg_data[6:0];
                    srlfo_pkg::CFG_WAVE_TYPE:     r_wave_type     <= i_cfg_data[0];
                    srlfo_pkg::CFG_STEREO_OFFSET: r_stereo_offset <= i_cfg_data[6:0];
                    default: ;
                endcase
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                srlfo_pkg::ST_IDLE: begin
                    if (w_in_acc) begin
                        if (i_kind == srlfo_pkg::KIND_TICK) begin
                            r_ch <= 1'b0;
                        end else begin
                            r_phase_r <= r_phase_l + w_off_tab[r_stereo_offset];
                        end
                    end
                end
                srlfo_pkg::ST_SAT: begin
                    if (r_ch) begin
                        r_phase_r <= w_nx[PHASE_BITS-1:0];
                    end else begin
                        r_phase_l <= w_nx[PHASE_BITS-1:0];
                    end
                    if (!w_nx[PHASE_BITS] && !r_ch) begin
                        r_ch <= 1'b1;
                    end
                end
                srlfo_pkg::ST_COR: begin
                    // wrap: end level moves to start, new end drawn
                    if (r_ch) begin
                        r_amp0_r <= r_amp1_r;
                        r_amp1_r <= w_new_end;
                    end else begin
                        r_amp0_l <= r_amp1_l;
                        r_amp1_l <= w_new_end;
                        r_ch     <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_rnd_l <= i_random_left;
            r_rnd_r <= i_random_right;
        end
        if (r_state == srlfo_pkg::ST_AMP) begin
            r_shape <= w_shape;
        end
        if (r_state == srlfo_pkg::ST_DIV) begin
            r_m <= w_n[22:1];
        end
        if (r_state == srlfo_pkg::ST_SAT) begin
            if (r_ch) begin
                r_lvl_r <= w_level;
            end else begin
                r_lvl_l <= w_level;
            end
        end
        if (w_out_load) begin
            r_out_l <= r_lvl_l;
            r_out_r <= r_lvl_r;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_left_level  = r_out_l;
    assign o_right_level = r_out_r;

endmodule
`default_nettype wire
